@@ src/fmul_pkg.sv @@
// ----------------------------------------------------------------------------
// fmul_pkg: shared types and constants for the single-precision multiplier
// Operand and result transfer structs, field widths and exponent bounds.
// ----------------------------------------------------------------------------
package fmul_pkg;

  localparam int FRAC_W = 23;
  localparam int SIG_W  = 24;
  localparam int EXP_W  = 8;
  localparam int PROD_W = 48;
  localparam int EXP_CALC_W = 11;  // signed, holds -1024..1023

  localparam logic signed [EXP_CALC_W-1:0] BIAS    = 11'sd127;
  localparam logic signed [EXP_CALC_W-1:0] EXP_MAX = 11'sd254;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } fmul_in_t;

  typedef struct packed {
    logic [31:0] product;
    logic        overflow;
    logic        underflow;
  } fmul_out_t;

  // Data carried from one cell of the pipeline to the next.
  typedef struct packed {
    logic                         sgn;
    logic signed [EXP_CALC_W-1:0] exp;
    logic [SIG_W-1:0]             ma;
    logic [SIG_W-1:0]             mb;
    logic [PROD_W-1:0]            prod;
  } fmul_stage_t;

endpackage

@@ src/float32_multiplier.sv @@
// ----------------------------------------------------------------------------
// float32_multiplier: IEEE 754 single-precision multiply, round half up
// Three cells in a chain: unpack, 24x24 multiply, normalize/round/pack.
// ----------------------------------------------------------------------------
// An operand pair is registered in cell 0, then cell 1, then cell 2, which
// presents the result.
// Throughput: one operand pair per cycle while out_stall is low.
// Each cell advances whenever the next has room, so a held result stalls
// the chain only as far back as needed.
// Reset (rst, synchronous): clears all cell valid bits; payloads are not reset.
module float32_multiplier (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmul_pkg::fmul_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fmul_pkg::fmul_out_t out_data
);

  localparam int SW = $bits(fmul_pkg::fmul_stage_t);
  localparam int OW = $bits(fmul_pkg::fmul_out_t);

  fmul_pkg::fmul_stage_t unp, s0, mul_next, s1;
  fmul_pkg::fmul_out_t   res_next;
  logic v0, v1, r0, r1, r2;

  // Unpack
  always_comb begin
    unp      = '0;
    unp.sgn  = in_data.operand_a[31] ^ in_data.operand_b[31];
    unp.exp  = $signed({3'b000, in_data.operand_a[30:23]})
             + $signed({3'b000, in_data.operand_b[30:23]}) - fmul_pkg::BIAS;
    unp.ma   = {1'b1, in_data.operand_a[22:0]};
    unp.mb   = {1'b1, in_data.operand_b[22:0]};
  end

  fmul_cell #(.W(SW)) u_c0 (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(unp), .in_room(r0),
    .valid(v0), .data(s0), .out_room(r1)
  );

  always_comb begin
    mul_next      = s0;
    mul_next.prod = s0.ma * s0.mb;
  end

  fmul_cell #(.W(SW)) u_c1 (
    .clk(clk), .rst(rst), .in_valid(v0), .in_data(mul_next), .in_room(r1),
    .valid(v1), .data(s1), .out_room(r2)
  );

  // Normalize, round, pack
  logic                                  top;
  logic [fmul_pkg::PROD_W-1:0]           norm;
  logic [fmul_pkg::FRAC_W:0]             frac_r;
  logic signed [fmul_pkg::EXP_CALC_W-1:0] e;

  always_comb begin
    top    = s1.prod[47];
    norm   = top ? s1.prod : {s1.prod[46:0], 1'b0};
    frac_r = {1'b0, norm[46:24]} + {23'd0, norm[23]};
    e      = s1.exp + (top ? 11'sd1 : 11'sd0) + (frac_r[23] ? 11'sd1 : 11'sd0);
    res_next = '0;
    res_next.product[31]   = s1.sgn;
    res_next.product[22:0] = frac_r[22:0];
    if (e > fmul_pkg::EXP_MAX) begin
      res_next.overflow = 1'b1;
    end else if (e < 11'sd1) begin
      res_next.underflow = 1'b1;
    end else begin
      res_next.product[30:23] = e[7:0];
    end
  end

  fmul_cell #(.W(OW)) u_c2 (
    .clk(clk), .rst(rst), .in_valid(v1), .in_data(res_next), .in_room(r2),
    .valid(out_valid), .data(out_data), .out_room(!out_stall)
  );

  assign in_stall = !r0;

  a_no_both_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.overflow && out_data.underflow))
    else $error("both flags set");
  a_flag_zero_exp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.overflow || out_data.underflow)
      |-> out_data.product[30:23] == 8'd0)
    else $error("flagged result has nonzero exponent");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && !r2 |=> v1 && $stable(s1))
    else $error("cell 1 lost data while stalled");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    v0 && r1 |=> v1)
    else $error("cell 0 transfer dropped");

endmodule

@@ src/fmul_cell.sv @@
// ----------------------------------------------------------------------------
// fmul_cell: one pipeline cell with local hold/advance control
// Registers a stage payload; advances when empty or when downstream has room.
// ----------------------------------------------------------------------------
module fmul_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         in_room,
  output logic         valid,
  output logic [W-1:0] data,
  input  logic         out_room
);

  assign in_room = !valid || out_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_room) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_room && in_valid) begin
      data <= in_data;
    end
  end

endmodule
